>>> src/swclk_pkg.sv
// ----------------------------------------------------------------------------
// Stopwatch clock package
// Event codes, field widths and the digit and segment helpers of the
// seven-segment stopwatch.
// ----------------------------------------------------------------------------
`default_nettype none

package swclk_pkg;

    // Event kinds carried on the input tuser field.
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_BUTTON    = 2'd1;
    localparam logic [1:0] ACT_STEP_FWD  = 2'd2;
    localparam logic [1:0] ACT_STEP_BACK = 2'd3;

    localparam int ACTION_W = 2;
    localparam int HOLD_W   = 16;
    localparam int MS_W     = 6;    // minutes and seconds counters
    localparam int HOUR_IN_W = 5;   // widest hour value the helpers take
    localparam int SEG_W    = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    localparam logic [MS_W-1:0] MS_MAX = 6'd59;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd150;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } digit_pair_t;

    // Seven-segment pattern of one decimal digit; non-decimal codes are dark.
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hFC;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'hDB;
            4'd3:    seg = 8'hF3;
            4'd4:    seg = 8'h67;
            4'd5:    seg = 8'hB7;
            4'd6:    seg = 8'hBF;
            4'd7:    seg = 8'hE4;
            4'd8:    seg = 8'hFF;
            4'd9:    seg = 8'hF7;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Split a minutes or seconds value below 64 into tens and ones.
    function automatic digit_pair_t split_ms(input logic [MS_W-1:0] v);
        digit_pair_t p;
        logic [MS_W-1:0] rem;
        priority if (v >= 6'd60)
        begin
            p.tens = 4'd6;
            rem    = v - 6'd60;
        end
        else if (v >= 6'd50)
        begin
            p.tens = 4'd5;
            rem    = v - 6'd50;
        end
        else if (v >= 6'd40)
        begin
            p.tens = 4'd4;
            rem    = v - 6'd40;
        end
        else if (v >= 6'd30)
        begin
            p.tens = 4'd3;
            rem    = v - 6'd30;
        end
        else if (v >= 6'd20)
        begin
            p.tens = 4'd2;
            rem    = v - 6'd20;
        end
        else if (v >= 6'd10)
        begin
            p.tens = 4'd1;
            rem    = v - 6'd10;
        end
        else
        begin
            p.tens = 4'd0;
            rem    = v;
        end
        p.ones = rem[3:0];
        return p;
    endfunction

    // Split an hour value below 32 into tens and ones.
    function automatic digit_pair_t split_hour(input logic [HOUR_IN_W-1:0] v);
        digit_pair_t p;
        logic [HOUR_IN_W-1:0] rem;
        priority if (v >= 5'd30)
        begin
            p.tens = 4'd3;
            rem    = v - 5'd30;
        end
        else if (v >= 5'd20)
        begin
            p.tens = 4'd2;
            rem    = v - 5'd20;
        end
        else if (v >= 5'd10)
        begin
            p.tens = 4'd1;
            rem    = v - 5'd10;
        end
        else
        begin
            p.tens = 4'd0;
            rem    = v;
        end
        p.ones = rem[3:0];
        return p;
    endfunction

endpackage

`default_nettype wire

>>> src/stopwatch_clock_seven_segment_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment stopwatch clock
// Keeps an hours:minutes:seconds count that wraps at HOUR_LIMIT hours and
// renders it as six segment bytes plus timer, stop and colon icons.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis channel is one event: tuser selects a second
//   tick, a start/stop button release, a step forward or a step back, and
//   tdata carries the button hold count. Each event gives exactly one beat
//   on the m_axis channel with the six digit patterns and the three icons.
//   An accepted event enters the input register; its result is shown on
//   m_axis once it moves into the result register. One event is taken in
//   every cycle while the receiver does not stall, since the state update
//   and the digit decode are a single combinational step between the input
//   register and the result register.
//   When the receiver stalls, the result register holds its beat, the input
//   register holds the next event, and s_axis_tready drops only when both
//   are full.
//   Reset clears the time to 0:00:00, sets the running flag and the colon,
//   and loads the long-press limit with 150. cfg_we writes the limit; the
//   user drives it only while no event is in flight; the block has no check.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_clock_seven_segment_unit #(
    parameter int HOUR_LIMIT = 12
) (
    input  wire                                  clk,
    input  wire                                  rst_n,

    // Event input. tdata: hold_polls[15:0]. tuser: action[1:0].
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [swclk_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire  [swclk_pkg::ACTION_W-1:0]       s_axis_tuser,

    // Display output. tdata: hour_tens_segments[7:0], hour_ones_segments,
    // minute_tens_segments, minute_ones_segments, second_tens_segments,
    // second_ones_segments, timer_icon[48], stopped_icon[49], colon_on[50],
    // zero fill [55:51].
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [swclk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    // Long-press limit register write.
    input  wire                                  cfg_we,
    input  wire  [swclk_pkg::HOLD_W-1:0]         cfg_wdata
);

    import swclk_pkg::*;

    localparam int HOUR_W = $clog2(HOUR_LIMIT + 1);
    localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(HOUR_LIMIT - 1);

    // Pipeline registers.
    logic                 in_valid_reg;
    logic [ACTION_W-1:0]  act_reg;
    logic [HOLD_W-1:0]    hold_reg;
    logic                 out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Clock state.
    logic [HOUR_W-1:0]    hour_reg, hour_next;
    logic [MS_W-1:0]      min_reg, min_next;
    logic [MS_W-1:0]      sec_reg, sec_next;
    logic                 run_reg, run_next;
    logic                 colon_reg, colon_next;
    logic [HOLD_W-1:0]    limit_reg;

    logic [HOUR_W-1:0]    fwd_hour, back_hour;
    logic [MS_W-1:0]      fwd_min, back_min, fwd_sec, back_sec;
    logic                 redraw;
    logic                 advance;
    logic                 in_accept;

    digit_pair_t          hour_dig, min_dig, sec_dig;

    // Handshake: the result stage moves when empty or taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Time one second ahead, wrapping through HOUR_LIMIT hours.
    always_comb
    begin
        fwd_hour = hour_reg;
        fwd_min  = min_reg;
        fwd_sec  = sec_reg + 6'd1;
        if (sec_reg >= MS_MAX)
        begin
            fwd_sec = '0;
            fwd_min = min_reg + 6'd1;
            if (min_reg >= MS_MAX)
            begin
                fwd_min  = '0;
                fwd_hour = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + HOUR_W'(1);
            end
        end
    end

    // Time one second back, wrapping from zero to the last hour.
    always_comb
    begin
        back_hour = hour_reg;
        back_min  = min_reg;
        back_sec  = sec_reg - 6'd1;
        if (sec_reg == '0)
        begin
            back_sec = MS_MAX;
            back_min = min_reg - 6'd1;
            if (min_reg == '0)
            begin
                back_min  = MS_MAX;
                back_hour = (hour_reg == '0) ? HOUR_MAX : hour_reg - HOUR_W'(1);
            end
        end
    end

    // Event decode and the next clock state.
    always_comb
    begin
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        run_next  = run_reg;
        redraw    = 1'b1;
        unique case (act_reg)
            ACT_TICK:
            begin
                redraw = run_reg;
                if (run_reg)
                begin
                    hour_next = fwd_hour;
                    min_next  = fwd_min;
                    sec_next  = fwd_sec;
                end
            end
            ACT_BUTTON:
            begin
                if (hold_reg > limit_reg)
                begin
                    run_next  = 1'b0;
                    hour_next = '0;
                    min_next  = '0;
                    sec_next  = '0;
                end
                else
                begin
                    run_next = !run_reg;
                end
            end
            ACT_STEP_FWD:
            begin
                hour_next = fwd_hour;
                min_next  = fwd_min;
                sec_next  = fwd_sec;
            end
            ACT_STEP_BACK:
            begin
                hour_next = back_hour;
                min_next  = back_min;
                sec_next  = back_sec;
            end
            default:
            begin
                redraw = 1'b0;
            end
        endcase

        // A redraw toggles the colon while running and lights it when stopped.
        colon_next = colon_reg;
        if (redraw)
        begin
            colon_next = run_next ? !colon_reg : 1'b1;
        end
    end

    // Digit split and segment patterns of the new time.
    always_comb
    begin
        hour_dig = split_hour(HOUR_IN_W'(hour_next));
        min_dig  = split_ms(min_next);
        sec_dig  = split_ms(sec_next);
        out_data_next = {5'd0, colon_next, !run_next, run_next,
                         seg_of(sec_dig.ones), seg_of(sec_dig.tens),
                         seg_of(min_dig.ones), seg_of(min_dig.tens),
                         seg_of(hour_dig.ones), seg_of(hour_dig.tens)};
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            run_reg       <= 1'b1;
            colon_reg     <= 1'b1;
            limit_reg     <= LONG_PRESS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    hour_reg  <= hour_next;
                    min_reg   <= min_next;
                    sec_reg   <= sec_next;
                    run_reg   <= run_next;
                    colon_reg <= colon_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= s_axis_tuser;
            hold_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

>>> sim/stopwatch_clock_seven_segment_unit_tb.sv
// ----------------------------------------------------------------------------
// Seven-segment stopwatch clock testbench
// A queue of events feeds a clocked driver on the s_axis side. Each accepted
// event is run through a local model of the stopwatch, and the display word
// it predicts is queued. A clocked monitor on the m_axis side checks every
// display beat field by field against the oldest prediction. The run goes
// through a directed part and several random phases with different
// long-press limits, idle rates and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_clock_seven_segment_unit_tb;

    import swclk_pkg::*;

    localparam int HOUR_LIMIT      = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 305;

    localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
        8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7
    };

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HOLD_W-1:0]   hold_polls;
    } stopwatch_event_t;

    // Block ports.
    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // hold_polls[15:0]
    logic [ACTION_W-1:0]    s_axis_tuser  = '0;   // action[1:0]
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Six segment bytes from hour tens up, timer, stopped, colon, zero fill.
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [HOLD_W-1:0]      cfg_wdata     = '0;

    // Local copy of the stopwatch state and the long-press limit.
    logic [3:0]        hour_now    = 4'd0;
    logic [MS_W-1:0]   minute_now  = '0;
    logic [MS_W-1:0]   second_now  = '0;
    logic              running_now = 1'b1;
    logic              colon_now   = 1'b1;
    logic [HOLD_W-1:0] press_limit = LONG_PRESS_RESET;

    // Pending events and predicted display words.
    stopwatch_event_t         pending_events [$];
    logic [OUT_TDATA_W-1:0]   display_expected [$];

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic hold_off_req       = 1'b0;
    int   hold_off_left      = 0;
    int   error_count        = 0;

    string field_names [9] = '{
        "hour_tens_segments", "hour_ones_segments", "minute_tens_segments",
        "minute_ones_segments", "second_tens_segments", "second_ones_segments",
        "timer_icon", "stopped_icon", "colon_on"
    };

    stopwatch_clock_seven_segment_unit #(
        .HOUR_LIMIT(HOUR_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock with a period of 8.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Advance the local time by one second, wrapping at the hour limit.
    task automatic advance_one_second();
        if (second_now == MS_MAX)
        begin
            second_now = '0;
            if (minute_now == MS_MAX)
            begin
                minute_now = '0;
                hour_now = (hour_now == HOUR_LIMIT - 1) ? 4'd0 : hour_now + 4'd1;
            end
            else
            begin
                minute_now = minute_now + 1'b1;
            end
        end
        else
        begin
            second_now = second_now + 1'b1;
        end
    endtask

    // Apply one event to the local state and build the display word it gives.
    task automatic predict_display(input stopwatch_event_t ev,
                                   output logic [OUT_TDATA_W-1:0] word);
        case (ev.action)
            ACT_TICK:
            begin
                // A tick while stopped leaves time and colon alone.
                if (running_now)
                begin
                    advance_one_second();
                    colon_now = !colon_now;
                end
            end
            ACT_BUTTON:
            begin
                if (ev.hold_polls > press_limit)
                begin
                    running_now = 1'b0;
                    hour_now    = 4'd0;
                    minute_now  = '0;
                    second_now  = '0;
                end
                else
                begin
                    running_now = !running_now;
                end
                colon_now = running_now ? !colon_now : 1'b1;
            end
            ACT_STEP_FWD:
            begin
                advance_one_second();
                colon_now = running_now ? !colon_now : 1'b1;
            end
            default:
            begin
                if (second_now == '0)
                begin
                    second_now = MS_MAX;
                    if (minute_now == '0)
                    begin
                        minute_now = MS_MAX;
                        hour_now = (hour_now == 4'd0) ? 4'(HOUR_LIMIT - 1)
                                                      : hour_now - 4'd1;
                    end
                    else
                    begin
                        minute_now = minute_now - 1'b1;
                    end
                end
                else
                begin
                    second_now = second_now - 1'b1;
                end
                colon_now = running_now ? !colon_now : 1'b1;
            end
        endcase

        word = '0;
        word[7:0]   = DIGIT_SEGMENTS[hour_now / 10];
        word[15:8]  = DIGIT_SEGMENTS[hour_now % 10];
        word[23:16] = DIGIT_SEGMENTS[minute_now / 10];
        word[31:24] = DIGIT_SEGMENTS[minute_now % 10];
        word[39:32] = DIGIT_SEGMENTS[second_now / 10];
        word[47:40] = DIGIT_SEGMENTS[second_now % 10];
        word[48]    = running_now;
        word[49]    = !running_now;
        word[50]    = colon_now;
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    // Event driver: predicts each accepted beat, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin : event_driver
        logic [OUT_TDATA_W-1:0] predicted;
        stopwatch_event_t       next_ev;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_display('{action: s_axis_tuser, hold_polls: s_axis_tdata},
                                predicted);
                display_expected.push_back(predicted);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_events.size() != 0 &&
                    $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    next_ev = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_ev.hold_polls;
                    s_axis_tuser  <= next_ev.action;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Display monitor: checks each accepted beat, then picks the next tready.
    always @(posedge clk or negedge rst_n)
    begin : display_monitor
        logic [OUT_TDATA_W-1:0] want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (display_expected.size() == 0)
                begin
                    report_mismatch("display beat with nothing expected",
                                    64'(m_axis_tdata), 64'd0);
                end
                else
                begin
                    want = display_expected.pop_front();
                    for (int f = 0; f < 6; f++)
                    begin
                        if (m_axis_tdata[f*8 +: 8] !== want[f*8 +: 8])
                            report_mismatch(field_names[f], 64'(m_axis_tdata[f*8 +: 8]),
                                            64'(want[f*8 +: 8]));
                    end
                    for (int b = 0; b < 3; b++)
                    begin
                        if (m_axis_tdata[48 + b] !== want[48 + b])
                            report_mismatch(field_names[6 + b], 64'(m_axis_tdata[48 + b]),
                                            64'(want[48 + b]));
                    end
                    if (m_axis_tdata[55:51] !== 5'd0)
                        report_mismatch("zero fill", 64'(m_axis_tdata[55:51]), 64'd0);
                end
            end
            m_axis_tready <= (hold_off_left == 0) &&
                             ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_off_left <= 0;
        else if (hold_off_req)
            hold_off_left <= HOLD_OFF_CYCLES;
        else if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic queue_event(input logic [ACTION_W-1:0] action,
                               input logic [HOLD_W-1:0] hold);
        pending_events.push_back('{action: action, hold_polls: hold});
    endtask

    // Random event, mostly ticks and steps, with presses near the limit.
    function automatic stopwatch_event_t random_event();
        stopwatch_event_t ev;
        int               pick;
        pick = $urandom_range(99, 0);
        ev.hold_polls = HOLD_W'($urandom_range(65535, 0));
        if (pick < 45)
            ev.action = ACT_TICK;
        else if (pick < 70)
            ev.action = ACT_STEP_FWD;
        else if (pick < 90)
            ev.action = ACT_STEP_BACK;
        else
        begin
            ev.action = ACT_BUTTON;
            case ($urandom_range(5, 0))
                0: ev.hold_polls = press_limit;
                1: ev.hold_polls = (press_limit == '1) ? press_limit
                                                       : press_limit + 16'd1;
                2, 3, 4: ev.hold_polls = HOLD_W'($urandom_range(press_limit, 0));
                default: ;
            endcase
        end
        return ev;
    endfunction

    // Wait until every event is sent and every display beat has arrived.
    // The check runs on the falling edge, after all rising-edge updates settle.
    task automatic wait_for_idle();
        @(negedge clk);
        while (pending_events.size() != 0 || s_axis_tvalid ||
               display_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Start a random phase with a new limit and new idle rates.
    task automatic start_phase(input logic [HOLD_W-1:0] limit, input int idle_pct,
                               input int stall_pct);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we             <= 1'b0;
        press_limit        = limit;
        sender_idle_pct    <= idle_pct;
        receiver_stall_pct <= stall_pct;
        @(posedge clk);
        for (int i = 0; i < PHASE_ITEMS; i++)
            pending_events.push_back(random_event());
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed events against the reset limit.
        queue_event(ACT_TICK, 16'd0);
        queue_event(ACT_STEP_BACK, 16'hFFFF);
        // Step back through midnight, forward and by tick over it again.
        queue_event(ACT_STEP_BACK, 16'd0);
        queue_event(ACT_STEP_FWD, 16'd0);
        queue_event(ACT_STEP_BACK, 16'd0);
        queue_event(ACT_TICK, 16'hFFFF);
        // A hold equal to the limit is a short press: stop.
        queue_event(ACT_BUTTON, LONG_PRESS_RESET);
        // Tick and steps while stopped.
        queue_event(ACT_TICK, 16'hFFFF);
        queue_event(ACT_STEP_FWD, 16'hFFFF);
        queue_event(ACT_STEP_BACK, 16'd0);
        queue_event(ACT_STEP_BACK, 16'd0);
        queue_event(ACT_BUTTON, 16'd0);
        queue_event(ACT_STEP_FWD, 16'd0);
        // Long presses, while running and while stopped.
        queue_event(ACT_BUTTON, LONG_PRESS_RESET + 16'd1);
        queue_event(ACT_BUTTON, 16'hFFFF);
        queue_event(ACT_BUTTON, LONG_PRESS_RESET);
        queue_event(ACT_TICK, 16'd0);
        queue_event(ACT_BUTTON, LONG_PRESS_RESET + 16'd1);
        queue_event(ACT_TICK, 16'd0);
        queue_event(ACT_BUTTON, 16'd1);
        queue_event(ACT_TICK, 16'd0);
        queue_event(ACT_STEP_FWD, 16'hAAAA);
        queue_event(ACT_STEP_BACK, 16'h5555);
        wait_for_idle();

        // Random phases over several limits and idle patterns.
        start_phase(16'd0, 0, 0);
        wait_for_idle();
        start_phase(16'hFFFF, 78, 0);
        wait_for_idle();
        start_phase(HOLD_W'($urandom_range(65535, 0)), 0, 78);
        wait_for_idle();
        start_phase(16'd1, 7, 7);
        wait_for_idle();

        // Receiver holds off while the sender keeps offering beats.
        start_phase(LONG_PRESS_RESET, 0, 0);
        hold_off_req <= 1'b1;
        @(posedge clk);
        hold_off_req <= 1'b0;
        wait_for_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
